FILE: hw/rtl/ptqs_pkg.sv
package ptqs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LEVEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MIN   = 8'd1;

  localparam logic [4:0] SPLIT_LEVEL_RST = 5'd5;
  localparam logic [3:0] SPLIT_MIN_RST   = 4'd2;

  localparam logic [31:0] SPLIT_ID_FACTOR = 32'd100;

  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_POP     = 2'd1;
  localparam logic [1:0] FUNC_REQUEUE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;
  localparam logic [1:0] ST_SPLIT = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] task_id;
    logic [2:0]  task_priority;
    logic [3:0]  task_duration;
    logic        task_critical;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [31:0] out_id;
    logic [2:0]  out_priority;
    logic [3:0]  out_duration;
    logic        out_critical;
    logic [4:0]  occupancy;
  } out_t;

  // one stored task, 40 bits
  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  prio;
    logic [3:0]  dur;
    logic        crit;
  } task_t;

  localparam int unsigned TASK_W = $bits(task_t);

  // a strictly better than b: critical first, then lower priority number
  function automatic logic better(task_t a, task_t b);
    logic res;
    if (a.crit != b.crit) begin
      res = a.crit;
    end else begin
      res = (a.prio < b.prio);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/ptqs_ram.sv
module ptqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/priority_task_queue_split_top.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o   ptqs_pkg::in_t  (func, task fields)
// out       output     out_valid_o/out_stall_i ptqs_pkg::out_t (status, popped task, occupancy)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Steps: an add or requeue is accepted, then written to the RAM in one write; a split add
// makes two RAM writes. A pop scans the entries one RAM read a cycle, then moves the tail
// behind the winner down one slot a cycle. The task RAM has separate write and read ports,
// and its read data is registered.
// Reset clears the control state and the entry count; the task RAM itself is not cleared.
// in_stall_o is high while an item is in work; a finished result sits in the output
// register, so the next item is accepted while it waits and only waits to finish.
module priority_task_queue_split_top #(
  parameter int unsigned QueueDepth = ptqs_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ptqs_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ptqs_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ptqs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptqs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  // common width for comparing the count against the 5-bit level register
  localparam int unsigned LW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] DEPTH_C     = CW'(QueueDepth);
  localparam logic [CW-1:0] DEPTH_M2_C  = CW'(QueueDepth - 2);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DISP   = 5'b00010,
    S_SPLIT2 = 5'b00100,
    S_SCAN   = 5'b01000,
    S_SHIFT  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  ptqs_pkg::in_t       item_q, item_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pidx_q, pidx_d;
  ptqs_pkg::task_t     best_q, best_d;
  logic [AW-1:0]       bidx_q, bidx_d;
  logic [31:0]         base_q, base_d;
  logic [4:0]          level_q;
  logic [3:0]          min_dur_q;

  logic                out_vld_q, out_vld_d;
  ptqs_pkg::out_t      out_q, res_d;
  logic                res_set;
  logic                res_free;

  // RAM port signals
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  ptqs_pkg::task_t     ram_wdata;
  logic [AW-1:0]       ram_raddr;
  ptqs_pkg::task_t     ram_rdata;

  logic                split;
  logic [31:0]         base;
  logic [3:0]          dur_lo;
  logic                rd_more;

  ptqs_ram #(
    .Width (ptqs_pkg::TASK_W),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // output register can take a result this cycle
  assign res_free = !out_vld_q || !out_stall_i;

  assign split = (item_q.func == ptqs_pkg::FUNC_ADD) &&
                 (LW'(count_q) > LW'(level_q)) &&
                 (item_q.task_duration > min_dur_q);
  assign base    = item_q.task_id * ptqs_pkg::SPLIT_ID_FACTOR;
  assign dur_lo  = item_q.task_duration >> 1;
  assign rd_more = (ptr_q < count_q);

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    base_d    = base_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = '{id: item_q.task_id, prio: item_q.task_priority,
                  dur: item_q.task_duration, crit: item_q.task_critical};
    ram_raddr = ptr_q[AW-1:0];
    res_set   = 1'b0;
    res_d     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        if (res_free) begin
          unique case (item_q.func) inside
            ptqs_pkg::FUNC_ADD, ptqs_pkg::FUNC_REQUEUE: begin
              if (split) begin
                if (count_q <= DEPTH_M2_C) begin
                  // first half now, second half next cycle
                  ram_we        = 1'b1;
                  ram_wdata.id  = base;
                  ram_wdata.dur = dur_lo;
                  base_d        = base;
                  count_d       = count_q + CW'(1);
                  state_d       = S_SPLIT2;
                end else begin
                  res_set      = 1'b1;
                  res_d.status = ptqs_pkg::ST_DROP;
                  state_d      = S_IDLE;
                end
              end else if (count_q < DEPTH_C) begin
                ram_we       = 1'b1;
                count_d      = count_q + CW'(1);
                res_set      = 1'b1;
                res_d.status = ptqs_pkg::ST_OK;
                state_d      = S_IDLE;
              end else begin
                res_set      = 1'b1;
                res_d.status = ptqs_pkg::ST_DROP;
                state_d      = S_IDLE;
              end
            end
            ptqs_pkg::FUNC_POP: begin
              if (count_q == '0) begin
                res_set      = 1'b1;
                res_d.status = ptqs_pkg::ST_EMPTY;
                state_d      = S_IDLE;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_set      = 1'b1;
              res_d.status = ptqs_pkg::ST_OK;
              state_d      = S_IDLE;
            end
          endcase
        end
      end

      S_SPLIT2: begin
        ram_we        = 1'b1;
        ram_wdata.id  = base_q + 32'd1;
        ram_wdata.dur = item_q.task_duration - dur_lo;
        count_d       = count_q + CW'(1);
        res_set       = 1'b1;
        res_d.status  = ptqs_pkg::ST_SPLIT;
        state_d       = S_IDLE;
      end

      S_SCAN: begin
        if (rd_more) begin
          ptr_d  = ptr_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = ptr_q[AW-1:0];
        end
        // strict compare keeps the oldest among equal keys
        if (pend_q) begin
          if ((pidx_q == '0) || ptqs_pkg::better(ram_rdata, best_q)) begin
            best_d = ram_rdata;
            bidx_d = pidx_q;
          end
        end
        if (!rd_more && !pend_q) begin
          ptr_d   = CW'(bidx_q) + CW'(1);
          state_d = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (rd_more) begin
          ptr_d  = ptr_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = ptr_q[AW-1:0];
        end
        // entry read last cycle moves down one slot
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!rd_more && !pend_q) begin
          count_d            = count_q - CW'(1);
          res_set            = 1'b1;
          res_d.status       = ptqs_pkg::ST_OK;
          res_d.out_valid    = 1'b1;
          res_d.out_id       = best_q.id;
          res_d.out_priority = best_q.prio;
          res_d.out_duration = best_q.dur;
          res_d.out_critical = best_q.crit;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.occupancy = 5'(count_d);
  end

  always_comb begin
    if (res_set) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
      level_q   <= ptqs_pkg::SPLIT_LEVEL_RST;
      min_dur_q <= ptqs_pkg::SPLIT_MIN_RST;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          ptqs_pkg::CFG_SPLIT_LEVEL: level_q   <= cfg_data_i[4:0];
          ptqs_pkg::CFG_SPLIT_MIN:   min_dur_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pidx_q <= pidx_d;
    best_q <= best_d;
    bidx_q <= bidx_d;
    base_q <= base_d;
    if (res_set) begin
      out_q <= res_d;
    end
  end

endmodule

FILE: test/priority_task_queue_split_top_tb.sv
`timescale 1ns / 1ps

module priority_task_queue_split_top_tb;
  import ptqs_pkg::*;

  // func code 3 is unused by the block: it reports ok and the current occupancy
  localparam logic [1:0] FuncIgnored = 2'd3;
  // first register index past the end of the list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CfgIdxUnused = 8'd2;

  // cycles without any accepted transaction before the run is declared hung;
  // the limit must cover the worst pop plus a random output stall
  localparam int unsigned QuietLimit = 5000;
  // settle time after the last result, covers the longest pop scan
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned MaxReports = 10;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  priority_task_queue_split_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: tasks in arrival order plus both split registers
  // ---------------------------------------------------------------------------
  task_t       task_store[$];
  logic [4:0]  split_level = SPLIT_LEVEL_RST;
  logic [3:0]  split_min   = SPLIT_MIN_RST;

  in_t         pending_items[$];     // filled by the sequencer, drained by the driver
  out_t        expected_results[$];  // one per accepted input transaction
  out_t        oldest_result;

  int unsigned idle_pct = 31;        // chance in percent of a gap on either side
  bit          in_taken;             // input transaction seen at the last rising edge
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // Apply one operation to the shadow queue and return its result.
  function automatic out_t apply_queue_op(in_t op);
    out_t        res;
    task_t       entry;
    logic [3:0]  first_half;
    int          best;
    bit          do_split;
    res = '0;
    case (op.func)
      FUNC_ADD, FUNC_REQUEUE: begin
        // split only fresh adds that arrive at a busy queue and are long enough
        do_split = (op.func == FUNC_ADD) && (task_store.size() > int'(split_level)) &&
                   (op.task_duration > split_min);
        entry.prio = op.task_priority;
        entry.crit = op.task_critical;
        if (do_split) begin
          // both halves or nothing: no fallback to a whole insert
          if (int'(QUEUE_DEPTH) - task_store.size() >= 2) begin
            first_half = op.task_duration >> 1;
            entry.id   = op.task_id * SPLIT_ID_FACTOR;  // wraps at 32 bits
            entry.dur  = first_half;
            task_store.push_back(entry);
            entry.id   = entry.id + 32'd1;
            entry.dur  = op.task_duration - first_half;
            task_store.push_back(entry);
            res.status = ST_SPLIT;
          end else begin
            res.status = ST_DROP;
          end
        end else if (task_store.size() < int'(QUEUE_DEPTH)) begin
          entry.id  = op.task_id;
          entry.dur = op.task_duration;
          task_store.push_back(entry);
          res.status = ST_OK;
        end else begin
          res.status = ST_DROP;
        end
      end
      FUNC_POP: begin
        if (task_store.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // strict compare keeps the oldest among equal keys
          best = 0;
          for (int i = 1; i < task_store.size(); i++) begin
            if ((task_store[i].crit && !task_store[best].crit) ||
                (task_store[i].crit == task_store[best].crit &&
                 task_store[i].prio < task_store[best].prio)) begin
              best = i;
            end
          end
          res.out_valid    = 1'b1;
          res.out_id       = task_store[best].id;
          res.out_priority = task_store[best].prio;
          res.out_duration = task_store[best].dur;
          res.out_critical = task_store[best].crit;
          task_store.delete(best);
          res.status = ST_OK;
        end
      end
      default: begin
        // unused code: no state change
      end
    endcase
    res.occupancy = 5'(task_store.size());
    return res;
  endfunction

  task automatic report_mismatch(string what, out_t exp_r, out_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t %s: exp st=%0d v=%0d id=%h pr=%0d du=%0d cr=%0d occ=%0d", $realtime, what,
               exp_r.status, exp_r.out_valid, exp_r.out_id, exp_r.out_priority,
               exp_r.out_duration, exp_r.out_critical, exp_r.occupancy);
      $display("%0t %s: got st=%0d v=%0d id=%h pr=%0d du=%0d cr=%0d occ=%0d", $realtime, what,
               got.status, got.out_valid, got.out_id, got.out_priority,
               got.out_duration, got.out_critical, got.occupancy);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: input side sampled at the rising edge, driven at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(apply_queue_op(in_data));
      in_taken = 1'b1;
    end
  end

  // A held payload stays put until it is taken; gaps are chosen only between
  // transactions and never look at stall.
  always @(negedge clk) begin
    if (rst_n && (in_taken || !in_valid)) begin
      in_taken = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare against the oldest result
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data);
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_data !== oldest_result) begin
          report_mismatch("result mismatch", oldest_result, out_data);
        end
      end
    end
  end

  // Watchdog: any accepted transaction on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("** priority_task_queue_split_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  function automatic in_t make_op(logic [1:0] func, logic [31:0] id, logic [2:0] prio,
                                  logic [3:0] dur, logic crit);
    in_t op;
    op.func          = func;
    op.task_id       = id;
    op.task_priority = prio;
    op.task_duration = dur;
    op.task_critical = crit;
    return op;
  endfunction

  // Register writes happen only with the block idle, so the shadow copy is
  // updated right at the handshake.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SPLIT_LEVEL) begin
      split_level = value[4:0];
    end else if (idx == CFG_SPLIT_MIN) begin
      split_min = value[3:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: nothing queued, nothing in flight, then let the block settle.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random traffic in blocks of 40 that alternate between filling and draining,
  // so occupancy swings from empty to full and the split threshold is crossed
  // in both directions. Ignored codes ride along but are not counted.
  task automatic queue_random_ops(int unsigned count);
    in_t         op;
    int unsigned counted;
    int unsigned pop_pct;
    int unsigned r;
    counted = 0;
    pop_pct = 60;
    while (counted < count) begin
      if (counted % 40 == 0) begin
        pop_pct = (pop_pct == 20) ? 60 : 20;
      end
      op = make_op(FUNC_ADD, $urandom, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op.func = FuncIgnored;
      end else if (r < 3 + pop_pct) begin
        op.func = FUNC_POP;
      end else if (r < 3 + pop_pct + (97 - pop_pct) / 4) begin
        op.func = FUNC_REQUEUE;
      end
      if (op.func != FuncIgnored) begin
        counted++;
      end
      pending_items.push_back(op);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings: level 5, min duration 2
    pending_items.push_back(make_op(FUNC_POP, 32'hDEAD_BEEF, 3'd7, 4'd15, 1'b1));  // empty pop
    pending_items.push_back(make_op(FuncIgnored, 32'h1234_5678, 3'd1, 4'd1, 1'b0));
    pending_items.push_back(make_op(FUNC_ADD, 32'h0000_0000, 3'd0, 4'd0, 1'b0));
    pending_items.push_back(make_op(FUNC_ADD, 32'hFFFF_FFFF, 3'd7, 4'd15, 1'b1));
    pending_items.push_back(make_op(FUNC_REQUEUE, 32'h1234_5678, 3'd3, 4'd8, 1'b0));
    pending_items.push_back(make_op(FUNC_ADD, 32'hA5A5_A5A5, 3'd3, 4'd3, 1'b1));
    pending_items.push_back(make_op(FUNC_ADD, 32'h5A5A_5A5A, 3'd3, 4'd4, 1'b1));  // tie
    pending_items.push_back(make_op(FUNC_ADD, 32'd1, 3'd0, 4'd15, 1'b0));  // 5 held: whole
    pending_items.push_back(make_op(FUNC_ADD, 32'hFFFF_FFFF, 3'd2, 4'd15, 1'b0));  // split, wrap
    pending_items.push_back(make_op(FUNC_ADD, 32'd2, 3'd1, 4'd2, 1'b1));  // at min: whole
    pending_items.push_back(make_op(FUNC_REQUEUE, 32'd3, 3'd0, 4'd15, 1'b1));  // never split
    pending_items.push_back(make_op(FUNC_ADD, 32'd42949673, 3'd4, 4'd3, 1'b0));  // id*100 wraps
    pending_items.push_back(make_op(FUNC_ADD, 32'd7, 3'd5, 4'd13, 1'b1));
    pending_items.push_back(make_op(FUNC_ADD, 32'd8, 3'd6, 4'd9, 1'b0));  // now full
    pending_items.push_back(make_op(FUNC_ADD, 32'd9, 3'd0, 4'd0, 1'b1));  // full: drop
    pending_items.push_back(make_op(FUNC_REQUEUE, 32'd10, 3'd0, 4'd5, 1'b1));  // full: drop
    pending_items.push_back(make_op(FUNC_ADD, 32'd11, 3'd7, 4'd15, 1'b0));  // split, no room
    pending_items.push_back(make_op(FUNC_POP, 32'd0, 3'd0, 4'd0, 1'b0));
    pending_items.push_back(make_op(FUNC_ADD, 32'd12, 3'd1, 4'd15, 1'b1));  // one slot: drop
    pending_items.push_back(make_op(FUNC_ADD, 32'd13, 3'd2, 4'd1, 1'b0));  // fills last slot
    pending_items.push_back(make_op(FuncIgnored, 32'hFFFF_FFFF, 3'd7, 4'd15, 1'b1));
    repeat (4) pending_items.push_back(make_op(FUNC_POP, 32'd0, 3'd0, 4'd0, 1'b0));
    queue_random_ops(250);
    wait_drained();

    // most aggressive splitting
    write_register(CFG_SPLIT_LEVEL, 8'd0);
    write_register(CFG_SPLIT_MIN, 8'd0);
    queue_random_ops(250);
    wait_drained();

    // splitting disabled: level at full depth, min at maximum
    write_register(CFG_SPLIT_LEVEL, 8'd16);
    write_register(CFG_SPLIT_MIN, 8'd15);
    queue_random_ops(200);
    wait_drained();

    // write past the register list must not disturb the settings; then a long
    // back-to-back stretch with no gaps on either side
    write_register(CfgIdxUnused, 8'd3);
    write_register(CFG_SPLIT_LEVEL, 8'd10);
    write_register(CFG_SPLIT_MIN, 8'd7);
    idle_pct = 0;
    queue_random_ops(300);
    wait_drained();
    idle_pct = 31;

    // a few random settings
    repeat (3) begin
      write_register(CFG_SPLIT_LEVEL, 8'($urandom_range(0, 16)));
      write_register(CFG_SPLIT_MIN, 8'($urandom_range(0, 15)));
      queue_random_ops(240);
      wait_drained();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** priority_task_queue_split_top: PASSED **");
    end else begin
      $display("** priority_task_queue_split_top: FAILED **");
    end
    $finish;
  end

endmodule
